>>> src/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// shared constants, codes and control types of the usage time table
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int OCC_W   = 8;
    localparam int MIN_W   = 24;
    localparam int ENTRY_W = OCC_W + MIN_W;
    localparam int PROD_W  = MIN_W + OCC_W;
    localparam int DCNT_W  = $clog2(PROD_W + 1);

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_QUERY  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BELOW_MIN = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_PREV,
        RES_CUR,
        RES_INTERP
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_PREP,
        S_SHIFT,
        S_WR_UPD,
        S_WR_NEW,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    scan_next;
        logic    scan_stop;
        logic    idx_last;
        logic    idx_dec;
        logic    shift_wr;
        logic    wr_new;
        logic    count_inc;
        logic    mul;
        logic    div_step;
        logic    res_load;
        t_res    res_sel;
        t_status res_status;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic below_min;
        logic empty;
        logic full;
        logic at_end;
        logic at_first;
        logic occ_lt;
        logic occ_eq;
        logic shift_done;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

>>> src/plt_ctrl.sv
// ----------------------------------------------------------------------------
// plt_ctrl
// sequencer for table scan, sorted insert and serial interpolation
// ----------------------------------------------------------------------------
module plt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  plt_pkg::t_stat i_stat,
    output plt_pkg::t_cmd  o_cmd
);

    plt_pkg::t_state r_state;
    plt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == plt_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = plt_pkg::S_SCAN;
                end
            end
            plt_pkg::S_SCAN: begin
                priority if (i_stat.is_query && i_stat.below_min) begin
                    n_state = plt_pkg::S_OUT;
                end else if (i_stat.is_query && i_stat.empty) begin
                    n_state = plt_pkg::S_OUT;
                end else if (!i_stat.at_end && i_stat.occ_lt) begin
                    n_state = plt_pkg::S_SCAN;
                end else if (i_stat.is_query) begin
                    if (i_stat.at_end || i_stat.occ_eq || i_stat.at_first) begin
                        n_state = plt_pkg::S_OUT;
                    end else begin
                        n_state = plt_pkg::S_MUL;
                    end
                end else if (!i_stat.at_end && i_stat.occ_eq) begin
                    n_state = plt_pkg::S_WR_UPD;
                end else if (i_stat.full) begin
                    n_state = plt_pkg::S_OUT;
                end else if (i_stat.at_end) begin
                    n_state = plt_pkg::S_WR_NEW;
                end else begin
                    n_state = plt_pkg::S_SHIFT_PREP;
                end
            end
            plt_pkg::S_SHIFT_PREP: begin
                n_state = plt_pkg::S_SHIFT;
            end
            plt_pkg::S_SHIFT: begin
                if (i_stat.shift_done) begin
                    n_state = plt_pkg::S_WR_NEW;
                end
            end
            plt_pkg::S_WR_UPD: begin
                n_state = plt_pkg::S_OUT;
            end
            plt_pkg::S_WR_NEW: begin
                n_state = plt_pkg::S_OUT;
            end
            plt_pkg::S_MUL: begin
                n_state = plt_pkg::S_DIV;
            end
            plt_pkg::S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = plt_pkg::S_OUT;
                end
            end
            plt_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = plt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = plt_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_sel    = plt_pkg::RES_ZERO;
        o_cmd.res_status = plt_pkg::ST_OK;
        unique case (r_state)
            plt_pkg::S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            plt_pkg::S_SCAN: begin
                priority if (i_stat.is_query && i_stat.below_min) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = plt_pkg::ST_BELOW_MIN;
                end else if (i_stat.is_query && i_stat.empty) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = plt_pkg::ST_EMPTY;
                end else if (!i_stat.at_end && i_stat.occ_lt) begin
                    o_cmd.scan_next = 1'b1;
                end else if (i_stat.is_query) begin
                    o_cmd.scan_stop = 1'b1;
                    if (i_stat.at_end) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = plt_pkg::RES_PREV;
                    end else if (i_stat.occ_eq || i_stat.at_first) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = plt_pkg::RES_CUR;
                    end
                end else begin
                    o_cmd.scan_stop = 1'b1;
                    if (!(!i_stat.at_end && i_stat.occ_eq) && i_stat.full) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = plt_pkg::ST_FULL;
                    end
                end
            end
            plt_pkg::S_SHIFT_PREP: begin
                o_cmd.idx_last = 1'b1;
            end
            plt_pkg::S_SHIFT: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_dec  = !i_stat.shift_done;
            end
            plt_pkg::S_WR_UPD: begin
                o_cmd.wr_new   = 1'b1;
                o_cmd.res_load = 1'b1;
            end
            plt_pkg::S_WR_NEW: begin
                o_cmd.wr_new    = 1'b1;
                o_cmd.count_inc = 1'b1;
                o_cmd.res_load  = 1'b1;
            end
            plt_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
            end
            plt_pkg::S_DIV: begin
                if (i_stat.div_last) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = plt_pkg::RES_INTERP;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            plt_pkg::S_OUT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

endmodule

>>> src/plt_datapath.sv
// ----------------------------------------------------------------------------
// plt_datapath
// point table memory, scan compare, multiplier, serial divider, output stage
// ----------------------------------------------------------------------------
module plt_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [plt_pkg::OCC_W-1:0]        i_cfg_wdata,
    input  logic [plt_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic                             i_in_user,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [plt_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic [1:0]                       o_out_user,
    input  plt_pkg::t_cmd                    i_cmd,
    output plt_pkg::t_stat                   o_stat
);

    logic [plt_pkg::ENTRY_W-1:0] r_mem [plt_pkg::TABLE_DEPTH];
    logic [plt_pkg::ENTRY_W-1:0] r_rd_data;

    logic [plt_pkg::OCC_W-1:0]   r_min_occ;
    logic [plt_pkg::CNT_W-1:0]   r_count;
    logic [plt_pkg::CNT_W-1:0]   r_idx;
    logic [plt_pkg::CNT_W-1:0]   n_idx;
    logic [plt_pkg::CNT_W-1:0]   r_pos;

    logic                        r_mode;
    logic [plt_pkg::OCC_W-1:0]   r_occ;
    logic [plt_pkg::MIN_W-1:0]   r_mins;

    logic [plt_pkg::ENTRY_W-1:0] r_prev;
    logic [plt_pkg::ENTRY_W-1:0] r_cur;

    logic                        r_neg;
    logic [plt_pkg::OCC_W-1:0]   r_den;
    logic [plt_pkg::OCC_W-1:0]   r_rem;
    logic [plt_pkg::PROD_W-1:0]  r_quo;
    logic [plt_pkg::DCNT_W-1:0]  r_dcnt;

    logic [plt_pkg::MIN_W-1:0]   r_res_time;
    logic [1:0]                  r_res_status;
    logic                        r_out_valid;
    logic [plt_pkg::MIN_W-1:0]   r_out_time;
    logic [1:0]                  r_out_status;

    logic [plt_pkg::OCC_W-1:0]   w_rd_occ;
    logic [plt_pkg::CNT_W-1:0]   w_idx_inc;
    logic [plt_pkg::CNT_W-1:0]   w_count_dec;
    logic                        w_we;
    logic [plt_pkg::IDX_W-1:0]   w_waddr;
    logic [plt_pkg::ENTRY_W-1:0] w_wdata;

    logic [plt_pkg::MIN_W-1:0]   w_lo_min;
    logic [plt_pkg::MIN_W-1:0]   w_hi_min;
    logic [plt_pkg::OCC_W-1:0]   w_lo_occ;
    logic [plt_pkg::OCC_W-1:0]   w_hi_occ;
    logic                        w_neg;
    logic [plt_pkg::MIN_W-1:0]   w_dmin_abs;
    logic [plt_pkg::OCC_W-1:0]   w_dq;
    logic [plt_pkg::PROD_W-1:0]  w_prod;

    logic [plt_pkg::OCC_W:0]     w_trial;
    logic [plt_pkg::OCC_W:0]     w_diff;
    logic                        w_ge;
    logic [plt_pkg::MIN_W-1:0]   w_interp;
    logic [plt_pkg::MIN_W-1:0]   w_res_time;
    logic                        w_out_free;

    assign w_rd_occ    = r_rd_data[plt_pkg::ENTRY_W-1:plt_pkg::MIN_W];
    assign w_idx_inc   = r_idx + plt_pkg::CNT_W'(1);
    assign w_count_dec = r_count - plt_pkg::CNT_W'(1);

    // index of the entry whose data shows on the read port next cycle
    always_comb begin
        n_idx = r_idx;
        priority if (i_cmd.load) begin
            n_idx = '0;
        end else if (i_cmd.scan_next) begin
            n_idx = w_idx_inc;
        end else if (i_cmd.idx_last) begin
            n_idx = w_count_dec;
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - plt_pkg::CNT_W'(1);
        end
    end

    assign w_we    = i_cmd.shift_wr | i_cmd.wr_new;
    assign w_waddr = i_cmd.shift_wr ? w_idx_inc[plt_pkg::IDX_W-1:0]
                                    : r_pos[plt_pkg::IDX_W-1:0];
    assign w_wdata = i_cmd.shift_wr ? r_rd_data : {r_occ, r_mins};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[n_idx[plt_pkg::IDX_W-1:0]];
    end

    // interpolation operands: lo from previous entry, hi from current
    assign w_lo_min   = r_prev[plt_pkg::MIN_W-1:0];
    assign w_lo_occ   = r_prev[plt_pkg::ENTRY_W-1:plt_pkg::MIN_W];
    assign w_hi_min   = r_cur[plt_pkg::MIN_W-1:0];
    assign w_hi_occ   = r_cur[plt_pkg::ENTRY_W-1:plt_pkg::MIN_W];
    assign w_neg      = (w_hi_min < w_lo_min);
    assign w_dmin_abs = w_neg ? (w_lo_min - w_hi_min) : (w_hi_min - w_lo_min);
    assign w_dq       = r_occ - w_lo_occ;
    assign w_prod     = w_dmin_abs * w_dq;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[plt_pkg::PROD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    assign w_interp = r_neg ? (w_lo_min - r_quo[plt_pkg::MIN_W-1:0])
                            : (w_lo_min + r_quo[plt_pkg::MIN_W-1:0]);

    always_comb begin
        unique case (i_cmd.res_sel)
            plt_pkg::RES_ZERO:   w_res_time = '0;
            plt_pkg::RES_PREV:   w_res_time = r_prev[plt_pkg::MIN_W-1:0];
            plt_pkg::RES_CUR:    w_res_time = r_rd_data[plt_pkg::MIN_W-1:0];
            plt_pkg::RES_INTERP: w_res_time = w_interp;
            default:             w_res_time = '0;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_occ   <= plt_pkg::OCC_W'(1);
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_occ <= i_cfg_wdata;
            end
            if (i_cmd.count_inc) begin
                r_count <= r_count + plt_pkg::CNT_W'(1);
            end
            r_idx <= n_idx;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_in_user;
            r_occ  <= i_in_data[plt_pkg::OCC_W-1:0];
            r_mins <= i_in_data[plt_pkg::IN_DATA_W-1:plt_pkg::OCC_W];
        end
        if (i_cmd.scan_next) begin
            r_prev <= r_rd_data;
        end
        if (i_cmd.scan_stop) begin
            r_cur <= r_rd_data;
            r_pos <= r_idx;
        end
        if (i_cmd.mul) begin
            r_neg  <= w_neg;
            r_den  <= w_hi_occ - w_lo_occ;
            r_rem  <= '0;
            r_quo  <= w_prod;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff[plt_pkg::OCC_W-1:0] : w_trial[plt_pkg::OCC_W-1:0];
            r_quo  <= {r_quo[plt_pkg::PROD_W-2:0], w_ge};
            r_dcnt <= r_dcnt + plt_pkg::DCNT_W'(1);
        end
        if (i_cmd.res_load) begin
            r_res_time   <= w_res_time;
            r_res_status <= i_cmd.res_status;
        end
        if (i_cmd.out_load) begin
            r_out_time   <= r_res_time;
            r_out_status <= r_res_status;
        end
    end

    assign o_stat.is_query   = (r_mode == plt_pkg::MODE_QUERY);
    assign o_stat.below_min  = (r_occ < r_min_occ);
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count == plt_pkg::CNT_W'(plt_pkg::TABLE_DEPTH));
    assign o_stat.at_end     = (r_idx == r_count);
    assign o_stat.at_first   = (r_idx == '0);
    assign o_stat.occ_lt     = (w_rd_occ < r_occ);
    assign o_stat.occ_eq     = (w_rd_occ == r_occ);
    assign o_stat.shift_done = (r_idx == r_pos);
    assign o_stat.div_last   = (r_dcnt == plt_pkg::DCNT_W'(plt_pkg::PROD_W));
    assign o_stat.out_free   = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_time;
    assign o_out_user  = r_out_status;

endmodule

>>> src/piecewise_linear_time_table.sv
// ----------------------------------------------------------------------------
// piecewise_linear_time_table
// sorted (occupation, minutes) point table with clamped linear interpolation
// ----------------------------------------------------------------------------
// One item is in work at a time; the next is taken once the result has moved
// into the output register, which holds it until the master side takes the
// transfer. The table has one write and one read port and is walked one
// entry per cycle. A query ends with the scan for a below-minimum, empty,
// exact or clamped result; when it interpolates, a multiply step and the
// bit-serial divider follow the scan. An insert updates an equal entry or
// moves the later entries up one place to make room for a new one, and a
// full table rejects a new point.
// The minimum occupation register may be written while no item is in work.
// ----------------------------------------------------------------------------
module piecewise_linear_time_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,      // minimum_occupation
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // occupation[7:0], minutes[31:8]
    input  logic        i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // usage_time[23:0]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    plt_pkg::t_cmd  w_cmd;
    plt_pkg::t_stat w_stat;

    plt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    plt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the piecewise linear usage time table
// ----------------------------------------------------------------------------
// Drives insert and query transfers into the slave side and checks every
// result on the master side against a cycle-free model of the sorted point
// table, with its own copy of the points and the minimum occupation. A
// directed opening covers the empty table, the below-minimum check, clamping,
// exact points, rising and falling interpolation, updates and mid-table
// inserts. The random part grows the table until it is full, then keeps
// updating points and probing around them. Phases vary the sender gaps, the
// receiver stalls and the minimum occupation. One phase holds the receiver
// off long enough to back up the block, and one pauses the sender until
// every result is back.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 80;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [7:0]  i_cfg_wdata     = 8'd0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = 32'd0;   // occupation[7:0], minutes[31:8]
    logic        i_s_axis_tuser  = 1'b0;    // mode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;            // usage_time[23:0]
    logic [1:0]  o_m_axis_tuser;            // status[1:0]

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    typedef struct packed {
        logic [23:0]      usage_time;
        plt_pkg::t_status status;
    } t_usage_result;

    class usage_time_scoreboard;
        bit [7:0]      occ_tab [plt_pkg::TABLE_DEPTH];
        bit [23:0]     min_tab [plt_pkg::TABLE_DEPTH];
        int            n_pts;
        bit [7:0]      min_occ;
        t_usage_result due_results [$];
        int            errors;

        function new();
            n_pts = 0;
            min_occ = 8'd1;
            errors = 0;
        endfunction

        function void set_min_occ(bit [7:0] value);
            min_occ = value;
        endfunction

        function void apply_item(plt_pkg::t_mode mode, bit [7:0] occ, bit [23:0] mins);
            t_usage_result res;
            int            pos;
            longint        lo_m, hi_m, step, span;
            res.usage_time = 24'd0;
            res.status = plt_pkg::ST_OK;
            pos = 0;
            while (pos < n_pts && occ_tab[pos] < occ)
                pos++;
            if (mode == plt_pkg::MODE_INSERT) begin
                if (pos < n_pts && occ_tab[pos] == occ) begin
                    min_tab[pos] = mins;
                end else if (n_pts >= plt_pkg::TABLE_DEPTH) begin
                    res.status = plt_pkg::ST_FULL;
                end else begin
                    for (int i = n_pts; i > pos; i--) begin
                        occ_tab[i] = occ_tab[i - 1];
                        min_tab[i] = min_tab[i - 1];
                    end
                    occ_tab[pos] = occ;
                    min_tab[pos] = mins;
                    n_pts++;
                end
            end else if (occ < min_occ) begin
                res.status = plt_pkg::ST_BELOW_MIN;
            end else if (n_pts == 0) begin
                res.status = plt_pkg::ST_EMPTY;
            end else if (pos >= n_pts) begin
                res.usage_time = min_tab[n_pts - 1];
            end else if (pos == 0 || occ_tab[pos] == occ) begin
                res.usage_time = min_tab[pos];
            end else begin
                // signed division truncates toward zero on falling segments
                lo_m = min_tab[pos - 1];
                hi_m = min_tab[pos];
                step = occ - occ_tab[pos - 1];
                span = occ_tab[pos] - occ_tab[pos - 1];
                res.usage_time = 24'(lo_m + (hi_m - lo_m) * step / span);
            end
            due_results = {due_results, res};
        endfunction

        function void check_result(logic [23:0] usage_time, logic [1:0] status);
            t_usage_result want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending: usage_time %h status %0d",
                         $time, usage_time, status);
                return;
            end
            want = due_results.pop_front();
            if (usage_time !== want.usage_time) begin
                errors++;
                $display("%0t: usage_time mismatch: expected %h actual %h",
                         $time, want.usage_time, usage_time);
            end
            if (status !== want.status) begin
                errors++;
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, status);
            end
        endfunction
    endclass

    usage_time_scoreboard sb;

    piecewise_linear_time_table u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.apply_item(plt_pkg::t_mode'(i_s_axis_tuser), i_s_axis_tdata[7:0],
                              i_s_axis_tdata[31:8]);
            if ((o_m_axis_tvalid && i_m_axis_tready) ||
                (i_s_axis_tvalid && o_s_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic send_item(plt_pkg::t_mode mode, bit [7:0] occ, bit [23:0] mins);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {mins, occ};
        i_s_axis_tuser <= mode;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_min_occ(bit [7:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        sb.set_min_occ(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic bit [23:0] pick_minutes();
        case ($urandom_range(19))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic run_random(int count, int hold_at, int pause_at);
        for (int k = 0; k < count; k++) begin
            int       n;
            int       idx;
            bit [7:0] occ;
            if (k == hold_at)
                hold_request = 1;
            if (k == pause_at)
                drain();
            n = sb.n_pts;
            idx = (n > 0) ? $urandom_range(n - 1) : 0;
            occ = 8'($urandom);
            if ($urandom_range(99) < 12) begin
                if (n > 0 && $urandom_range(2) == 0)
                    occ = sb.occ_tab[idx];
                send_item(plt_pkg::MODE_INSERT, occ, pick_minutes());
            end else begin
                case ($urandom_range(7))
                    0, 1: if (n > 0) occ = sb.occ_tab[idx];
                    2:    if (n > 0) occ = sb.occ_tab[idx] + 8'd1;
                    3:    if (n > 0) occ = sb.occ_tab[idx] - 8'd1;
                    4:    occ = sb.min_occ - 8'($urandom_range(1));
                    5:    occ = $urandom_range(1) ? 8'd255 : 8'd0;
                    default: ;
                endcase
                send_item(plt_pkg::MODE_QUERY, occ, pick_minutes());
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, below minimum ahead of empty, single point clamps
        send_item(plt_pkg::MODE_QUERY,  8'd10,  24'hFFFFFF);
        send_item(plt_pkg::MODE_QUERY,  8'd0,   24'd0);
        send_item(plt_pkg::MODE_INSERT, 8'd100, 24'h000100);
        send_item(plt_pkg::MODE_QUERY,  8'd40,  24'd0);
        send_item(plt_pkg::MODE_QUERY,  8'd255, 24'd0);
        send_item(plt_pkg::MODE_QUERY,  8'd100, 24'd0);
        // rising segment up to full scale minutes
        send_item(plt_pkg::MODE_INSERT, 8'd200, 24'hFFFFFF);
        send_item(plt_pkg::MODE_QUERY,  8'd150, 24'd0);
        send_item(plt_pkg::MODE_QUERY,  8'd101, 24'd0);
        send_item(plt_pkg::MODE_QUERY,  8'd199, 24'd0);
        // falling segments, truncation toward zero
        send_item(plt_pkg::MODE_INSERT, 8'd0,   24'hABCDEF);
        send_item(plt_pkg::MODE_QUERY,  8'd0,   24'd0);
        send_item(plt_pkg::MODE_QUERY,  8'd1,   24'd0);
        send_item(plt_pkg::MODE_QUERY,  8'd50,  24'd0);
        send_item(plt_pkg::MODE_INSERT, 8'd255, 24'd0);
        send_item(plt_pkg::MODE_QUERY,  8'd254, 24'd0);
        send_item(plt_pkg::MODE_QUERY,  8'd255, 24'd0);
        // update in place, then insert mid-table
        send_item(plt_pkg::MODE_INSERT, 8'd100, 24'h800000);
        send_item(plt_pkg::MODE_QUERY,  8'd100, 24'd0);
        send_item(plt_pkg::MODE_QUERY,  8'd150, 24'd0);
        send_item(plt_pkg::MODE_INSERT, 8'd150, 24'h123456);
        send_item(plt_pkg::MODE_QUERY,  8'd149, 24'd0);
        send_item(plt_pkg::MODE_QUERY,  8'd175, 24'd0);

        write_min_occ(8'd0);
        run_random(220, -1, -1);

        src_idle_pct = 74;
        write_min_occ(8'($urandom_range(60, 1)));
        run_random(220, -1, -1);

        src_idle_pct = 0;
        snk_stall_pct = 74;
        write_min_occ(8'd255);
        run_random(60, -1, -1);

        write_min_occ(8'($urandom_range(100)));
        run_random(260, 20, -1);

        src_idle_pct = 7;
        snk_stall_pct = 7;
        write_min_occ(8'd1);
        run_random(270, -1, 130);

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
